FILE: src/swle_pkg.sv
package swle_pkg;

  // node weights are fixed 16-bit signed values
  localparam int WEIGHT_W = 16;

  // command codes carried on the input channel
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } swle_stat_t;

endpackage

FILE: src/swle_ram.sv
module swle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/swle_ctrl.sv
module swle_ctrl #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  cmd,
  input  logic [$clog2(NODE_COUNT)-1:0]         idx,
  input  logic signed [swle_pkg::WEIGHT_W-1:0]  wt,
  input  logic                                  res_ready,
  output swle_pkg::swle_stat_t                  stat,
  output logic [$clog2(NODE_COUNT):0]           head,
  output logic [$clog2(NODE_COUNT):0]           tail,
  output logic [$clog2(NODE_COUNT+1)-1:0]       count,
  output logic                                  rd_en,
  output logic [$clog2(NODE_COUNT)-1:0]         rd_addr,
  input  logic [swle_pkg::WEIGHT_W+2*($clog2(NODE_COUNT)+1)-1:0] rd_data,
  output logic                                  wr_en,
  output logic [$clog2(NODE_COUNT)-1:0]         wr_addr,
  output logic [swle_pkg::WEIGHT_W+2*($clog2(NODE_COUNT)+1)-1:0] wr_data
);

  import swle_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int EW = WEIGHT_W + 2 * LW;
  localparam logic [LW-1:0] NO_NODE = {LW{1'b1}};
  localparam logic [CW-1:0] NC_C = CW'(NODE_COUNT);

  // entry layout: {weight, prev link, next link}
  typedef enum logic [3:0] {
    S_IDLE, S_INS_EMPTY, S_WALK, S_LINK_N, S_LINK_C, S_HD_WN, S_PRV_RD,
    S_PRV_WR, S_RM_RD, S_RM_PV, S_NXT_RD, S_NXT_WR, S_DONE
  } state_t;

  state_t                      state_r, state_nxt, after_r, after_nxt;
  logic [IW-1:0]               n_r, n_nxt, a_r, a_nxt;
  logic signed [WEIGHT_W-1:0]  w_r, w_nxt;
  logic [LW-1:0]               cur_r, cur_nxt, v_r, v_nxt, pv_r, pv_nxt, nx_r, nx_nxt;
  logic [LW-1:0]               head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt, steps_r, steps_nxt;
  logic [EW-1:0]               ent_r, ent_nxt;

  always_comb begin
    logic signed [WEIGHT_W-1:0] rd_w;
    logic signed [WEIGHT_W-1:0] cmp_w;
    logic [LW-1:0]              rd_prev;
    logic [LW-1:0]              rd_next;
    logic [LW-1:0]              ent_prev;
    logic [LW-1:0]              ent_next;
    logic [LW-1:0]              n_link;
    logic                       to_head;

    rd_w     = $signed(rd_data[EW-1 -: WEIGHT_W]);
    rd_prev  = rd_data[2*LW-1:LW];
    rd_next  = rd_data[LW-1:0];
    ent_prev = ent_r[2*LW-1:LW];
    ent_next = ent_r[LW-1:0];
    n_link   = {1'b0, n_r};
    to_head  = 1'b0;
    cmp_w    = rd_w;

    state_nxt = state_r;
    after_nxt = after_r;
    n_nxt     = n_r;
    a_nxt     = a_r;
    w_nxt     = w_r;
    cur_nxt   = cur_r;
    v_nxt     = v_r;
    pv_nxt    = pv_r;
    nx_nxt    = nx_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    ent_nxt   = ent_r;

    rd_en     = 1'b0;
    rd_addr   = cur_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = n_r;
    wr_data   = '0;
    stat.done = 1'b0;
    stat.busy = (state_r != S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = idx;
          w_nxt = wt;
          case (cmd)
            CMD_INSERT: begin
              if (cnt_r != NC_C) cnt_nxt = cnt_r + 1'b1;
              if (tail_r[LW-1]) begin
                state_nxt = S_INS_EMPTY;
              end else begin
                cur_nxt   = tail_r;
                steps_nxt = '0;
                rd_en     = 1'b1;
                rd_addr   = tail_r[IW-1:0];
                state_nxt = S_WALK;
              end
            end
            CMD_REMOVE: begin
              if (tail_r[LW-1]) begin
                state_nxt = S_DONE;
              end else begin
                if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
                rd_en     = 1'b1;
                rd_addr   = idx;
                state_nxt = S_RM_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_EMPTY: begin
        wr_en     = 1'b1;
        wr_data   = {w_r, head_r, NO_NODE};
        head_nxt  = n_link;
        tail_nxt  = n_link;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (steps_r == NC_C) begin
          to_head = 1'b1;
        end else begin
          steps_nxt = steps_r + 1'b1;
          // the node's own weight is already the new one
          if (cur_r == n_link) cmp_w = w_r;
          if (cmp_w < w_r) begin
            ent_nxt   = rd_data;
            state_nxt = S_LINK_N;
          end else if (rd_prev[LW-1]) begin
            to_head = 1'b1;
          end else begin
            cur_nxt = rd_prev;
            rd_en   = 1'b1;
            rd_addr = rd_prev[IW-1:0];
          end
        end
        if (to_head) begin
          if (head_r[LW-1]) begin
            state_nxt = S_HD_WN;
          end else begin
            a_nxt     = head_r[IW-1:0];
            v_nxt     = n_link;
            after_nxt = S_HD_WN;
            state_nxt = S_PRV_RD;
          end
        end
      end
      S_LINK_N: begin
        wr_en     = 1'b1;
        wr_data   = {w_r, cur_r, ent_next};
        state_nxt = S_LINK_C;
      end
      S_LINK_C: begin
        wr_en   = 1'b1;
        wr_addr = cur_r[IW-1:0];
        wr_data = {ent_r[EW-1 -: WEIGHT_W], ent_prev, n_link};
        if (ent_next[LW-1]) begin
          tail_nxt  = n_link;
          state_nxt = S_DONE;
        end else begin
          a_nxt     = ent_next[IW-1:0];
          v_nxt     = n_link;
          after_nxt = S_DONE;
          state_nxt = S_PRV_RD;
        end
      end
      S_HD_WN: begin
        wr_en     = 1'b1;
        wr_data   = {w_r, NO_NODE, head_r};
        head_nxt  = n_link;
        state_nxt = S_DONE;
      end
      S_PRV_RD: begin
        rd_en     = 1'b1;
        rd_addr   = a_r;
        state_nxt = S_PRV_WR;
      end
      S_PRV_WR: begin
        wr_en     = 1'b1;
        wr_addr   = a_r;
        wr_data   = {rd_w, v_r, rd_next};
        state_nxt = after_r;
      end
      S_RM_RD: begin
        pv_nxt = rd_prev;
        nx_nxt = rd_next;
        if (rd_next[LW-1]) begin
          tail_nxt  = rd_prev;
          state_nxt = S_RM_PV;
        end else begin
          a_nxt     = rd_next[IW-1:0];
          v_nxt     = rd_prev;
          after_nxt = S_RM_PV;
          state_nxt = S_PRV_RD;
        end
      end
      S_RM_PV: begin
        if (pv_r[LW-1]) begin
          head_nxt  = nx_r;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NXT_RD;
        end
      end
      S_NXT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = pv_r[IW-1:0];
        state_nxt = S_NXT_WR;
      end
      S_NXT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = pv_r[IW-1:0];
        wr_data   = {rd_w, rd_prev, nx_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          stat.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_DONE;
      head_r  <= NO_NODE;
      tail_r  <= NO_NODE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r     <= n_nxt;
    a_r     <= a_nxt;
    w_r     <= w_nxt;
    cur_r   <= cur_nxt;
    v_r     <= v_nxt;
    pv_r    <= pv_nxt;
    nx_r    <= nx_nxt;
    steps_r <= steps_nxt;
    ent_r   <= ent_nxt;
  end

  assign head  = head_r;
  assign tail  = tail_r;
  assign count = cnt_r;

endmodule

FILE: src/sorted_weight_list_engine_core.sv
// sequence: an insert into an empty list writes the node and completes; other inserts first walk
//   back from the tail, one node memory read per node, then link it in beside its neighbors
// remove: goes straight to completion on an empty list, otherwise read-modify-write of neighbors
// throughput: one item at a time; the next item is taken the cycle after the result is loaded
// reset: synchronous active low; list empties (head and tail -1, count 0), node memory
//   contents stay undefined until written
module sorted_weight_list_engine_core #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_command,
  input  logic [$clog2(NODE_COUNT)-1:0]           in_node_index,
  input  logic signed [swle_pkg::WEIGHT_W-1:0]    in_node_weight,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [$clog2(NODE_COUNT):0]      out_head_index,
  output logic signed [$clog2(NODE_COUNT):0]      out_tail_index,
  output logic [$clog2(NODE_COUNT+1)-1:0]         out_entry_count
);

  import swle_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int EW = WEIGHT_W + 2 * LW;
  localparam logic [IW:0] NC_X = LW'(NODE_COUNT);

  swle_stat_t     stat;
  logic           start;
  logic           res_ready;
  logic [IW:0]    idx_ext;
  logic [IW:0]    idx_red;
  logic [LW-1:0]  head, tail;
  logic [CW-1:0]  count;

  // node memory port
  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic [EW-1:0]  rd_data, wr_data;

  // result register
  logic           out_valid_r;
  logic [LW-1:0]  out_head_r, out_tail_r;
  logic [CW-1:0]  out_count_r;

  // an item is taken whenever the sequencer is idle, even while a result waits
  assign in_stall = stat.busy;
  assign start    = in_valid && !in_stall;

  // index wraps at the table size: it is always below twice the size, so one
  // compare and subtract is enough (never taken for a power-of-two table)
  assign idx_ext = {1'b0, in_node_index};
  assign idx_red = (idx_ext >= NC_X) ? (idx_ext - NC_X) : idx_ext;

  // sequencer finishes only into a free (or draining) result register
  assign res_ready = !out_valid_r || !out_stall;

  // one entry per node: weight plus both links
  swle_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // walk and relink sequencer, also holds head, tail and count
  swle_ctrl #(
    .NODE_COUNT (NODE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (in_command),
    .idx       (idx_red[IW-1:0]),
    .wt        (in_node_weight),
    .res_ready (res_ready),
    .stat      (stat),
    .head      (head),
    .tail      (tail),
    .count     (count),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // output register: loaded on completion, cleared once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (stat.done) begin
      out_head_r  <= head;
      out_tail_r  <= tail;
      out_count_r <= count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_index  = out_head_r;
  assign out_tail_index  = out_tail_r;
  assign out_entry_count = out_count_r;

  // a taken item always leaves the sequencer busy in the cycle after
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("sequencer idle right after taking an item");

  // completion always produces a result the next cycle
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_valid)
    else $error("completed item produced no result");

  // completion never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // count saturates at the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= NC_X))
    else $error("entry count beyond table size");

endmodule

FILE: tb/weight_list_checker.sv
module weight_list_checker #(
  parameter int NODE_COUNT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [$clog2(NODE_COUNT)-1:0]        in_node_index,
  input  logic signed [swle_pkg::WEIGHT_W-1:0] in_node_weight,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [$clog2(NODE_COUNT):0]   out_head_index,
  input  logic signed [$clog2(NODE_COUNT):0]   out_tail_index,
  input  logic [$clog2(NODE_COUNT+1)-1:0]      out_entry_count,
  output int                                   failures
);

  import swle_pkg::*;

  localparam int LW = $clog2(NODE_COUNT) + 1;
  localparam int CW = $clog2(NODE_COUNT + 1);

  typedef logic signed [LW-1:0] link_t;
  localparam link_t NO_LINK = '1;

  typedef struct packed {
    link_t         head;
    link_t         tail;
    logic [CW-1:0] count;
  } list_view_t;

  link_t                      back_link [NODE_COUNT];
  link_t                      fwd_link [NODE_COUNT];
  logic signed [WEIGHT_W-1:0] node_weight [NODE_COUNT];
  link_t                      head_node;
  link_t                      tail_node;
  int unsigned                linked_nodes = 0;

  list_view_t  views_due [$];
  int unsigned views_waiting = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  assign failures = int'(mismatches + views_waiting);

  // walk back from the tail past every node that is not lighter
  task automatic link_in(input link_t n, input logic signed [WEIGHT_W-1:0] w);
    link_t       cur;
    link_t       nx;
    int unsigned steps;
    cur = tail_node;
    steps = 0;
    node_weight[n] = w;
    if (linked_nodes < NODE_COUNT) linked_nodes++;
    if (cur < 0) begin
      fwd_link[n] = NO_LINK;
      back_link[n] = head_node;
      head_node = n;
      tail_node = n;
    end else begin
      while (cur >= 0) begin
        if (steps >= NODE_COUNT) begin
          cur = NO_LINK;
          break;
        end
        steps++;
        if (node_weight[cur] < w) break;
        cur = back_link[cur];
      end
      if (cur < 0) begin
        nx = head_node;
        if (nx >= 0) back_link[nx] = n;
        back_link[n] = NO_LINK;
        fwd_link[n] = nx;
        head_node = n;
      end else begin
        back_link[n] = cur;
        fwd_link[n] = fwd_link[cur];
        fwd_link[cur] = n;
        nx = fwd_link[n];
        if (nx < 0) tail_node = n;
        else back_link[nx] = n;
      end
    end
  endtask

  task automatic link_out(input link_t n);
    link_t pv;
    link_t nx;
    pv = back_link[n];
    nx = fwd_link[n];
    if (tail_node >= 0) begin
      if (linked_nodes > 0) linked_nodes--;
      if (nx >= 0) back_link[nx] = pv;
      else tail_node = pv;
      if (pv >= 0) fwd_link[pv] = nx;
      else head_node = nx;
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result %0d %s: expected %0d, got %0d",
                 $time, results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    list_view_t want;
    link_t      n;
    if (!rst_n) begin
      head_node = NO_LINK;
      tail_node = NO_LINK;
      linked_nodes = 0;
    end else begin
      // retire before predicting so an item never meets its own result
      if (out_valid && !out_stall) begin
        results_seen++;
        if (views_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: head %0d tail %0d count %0d",
                     $time, out_head_index, out_tail_index, out_entry_count);
        end else begin
          want = views_due.pop_front();
          check_field("head", 32'(want.head), 32'(out_head_index));
          check_field("tail", 32'(want.tail), 32'(out_tail_index));
          check_field("count", 32'(want.count), 32'(out_entry_count));
        end
      end
      if (in_valid && !in_stall) begin
        n = link_t'(int'(in_node_index) % NODE_COUNT);
        if (in_command == CMD_INSERT) link_in(n, in_node_weight);
        else link_out(n);
        want.head = head_node;
        want.tail = tail_node;
        want.count = CW'(linked_nodes);
        views_due.push_back(want);
      end
      views_waiting = views_due.size();
    end
  end

endmodule

FILE: tb/sorted_weight_list_engine_core_tb.sv
module sorted_weight_list_engine_core_tb;
  import swle_pkg::*;

  localparam int NODE_COUNT = 512;
  localparam int IW = $clog2(NODE_COUNT);

  // receiver freezes for a long stretch once this many results have come
  localparam int HOLD_AT_RESULT = 40;
  localparam int LONG_HOLD = 300;
  // worst quiet stretch is the long hold or a full-table walk plus both gaps
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_command = CMD_INSERT;
  logic [IW-1:0]                   in_node_index = '0;
  logic signed [WEIGHT_W-1:0]      in_node_weight = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b1;
  logic signed [IW:0]              out_head_index;
  logic signed [IW:0]              out_tail_index;
  logic [$clog2(NODE_COUNT+1)-1:0] out_entry_count;
  int                              failures;

  int unsigned items_sent = 0;
  int unsigned rx_taken = 0;
  int unsigned quiet_cycles = 0;
  // stimulus-side view of which nodes are linked, exact while ops are well formed
  bit          on_list [NODE_COUNT];
  int unsigned listed = 0;

  always #6 clk = ~clk;

  sorted_weight_list_engine_core #(
    .NODE_COUNT(NODE_COUNT)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_node_index  (in_node_index),
    .in_node_weight (in_node_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_head_index (out_head_index),
    .out_tail_index (out_tail_index),
    .out_entry_count(out_entry_count)
  );

  weight_list_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) list_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_node_index  (in_node_index),
    .in_node_weight (in_node_weight),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_head_index (out_head_index),
    .out_tail_index (out_tail_index),
    .out_entry_count(out_entry_count),
    .failures       (failures)
  );

  // idle cycles before an item; every fourth run of 64 goes without idling
  function automatic int unsigned pick_gap(input int unsigned seq);
    if ((seq / 64) % 4 == 1) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // extremes and a narrow band around zero so equal weights are common
  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(WEIGHT_W-1){1'b0}}};
      1: return {1'b0, {(WEIGHT_W-1){1'b1}}};
      2, 3: return WEIGHT_W'($urandom_range(0, 4)) - WEIGHT_W'(2);
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // random node in the wanted state, found by probing upward from a random start
  function automatic int find_node(input bit want_linked);
    int idx;
    idx = int'($urandom_range(0, NODE_COUNT - 1));
    while (on_list[idx] != want_linked) idx = (idx + 1) % NODE_COUNT;
    return idx;
  endfunction

  // offer one item at the falling edge and hold it until taken
  task automatic put_op(input logic cmd, input int idx,
                        input logic signed [WEIGHT_W-1:0] wt);
    int unsigned gap;
    gap = pick_gap(items_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_node_index <= idx[IW-1:0];
    in_node_weight <= wt;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    @(negedge clk);
    if (cmd == CMD_INSERT) begin
      if (!on_list[idx]) listed++;
      on_list[idx] = 1'b1;
    end else begin
      if (on_list[idx]) listed--;
      on_list[idx] = 1'b0;
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    wait (rx_taken == items_sent);
    @(negedge clk);
  endtask

  // result side: stall for a drawn number of cycles after each item taken
  initial begin : result_side
    int unsigned hold;
    hold = pick_gap(0);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        rx_taken++;
        // long freeze lets the block fill and push back on the sender
        hold = (rx_taken == HOLD_AT_RESULT) ? LONG_HOLD : pick_gap(rx_taken);
      end
    end
  end

  // watchdog on cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // plain inserts: empty list, append at tail, new head, equals go first
    put_op(CMD_INSERT, 0, 16'sd0);
    put_op(CMD_INSERT, NODE_COUNT - 1, 16'sh7fff);
    put_op(CMD_INSERT, 5, 16'sh8000);
    put_op(CMD_INSERT, 7, 16'sd0);
    put_op(CMD_INSERT, 9, 16'sh7fff);
    // unlink tail, head, middle, then down to empty
    put_op(CMD_REMOVE, NODE_COUNT - 1, pick_weight());
    put_op(CMD_REMOVE, 5, pick_weight());
    put_op(CMD_REMOVE, 0, pick_weight());
    put_op(CMD_REMOVE, 7, pick_weight());
    put_op(CMD_REMOVE, 9, pick_weight());
    // remove on an empty list changes nothing
    put_op(CMD_REMOVE, 9, pick_weight());
    // removing an unlinked node drives the count to zero with one node left,
    // then the last remove has to hold the count at zero
    put_op(CMD_INSERT, 1, 16'sd10);
    put_op(CMD_INSERT, 2, -16'sd5);
    put_op(CMD_REMOVE, 2, pick_weight());
    put_op(CMD_REMOVE, 2, pick_weight());
    put_op(CMD_REMOVE, 1, pick_weight());
    // re-inserting a linked node leaves a self loop on the tail's back link,
    // so the next lighter insert walks the full table before going to the head
    put_op(CMD_INSERT, 3, 16'sd1);
    put_op(CMD_INSERT, 4, 16'sd2);
    put_op(CMD_INSERT, 4, 16'sd3);
    put_op(CMD_INSERT, 6, 16'sd0);
    // removes on the looped node only drop the count; node 9 has no links
    // either way, so removing it empties the list and the count hits zero
    put_op(CMD_REMOVE, 4, pick_weight());
    put_op(CMD_REMOVE, 4, pick_weight());
    put_op(CMD_REMOVE, 4, pick_weight());
    put_op(CMD_REMOVE, 9, pick_weight());

    // sender pause until the directed items are all back; the list is empty again
    settle();
    for (int i = 0; i < NODE_COUNT; i++) on_list[i] = 1'b0;
    listed = 0;

    // mix of well-formed inserts and removes (six in ten are inserts) on a short list
    repeat (20) begin
      if (listed == 0 || $urandom_range(0, 9) < 6)
        put_op(CMD_INSERT, find_node(1'b0), pick_weight());
      else
        put_op(CMD_REMOVE, find_node(1'b1), pick_weight());
    end
    settle();

    // insert-heavy mix until every node is linked, so walks get long
    while (listed < NODE_COUNT) begin
      if (listed == 0 || $urandom_range(0, 99) < 98)
        put_op(CMD_INSERT, find_node(1'b0), pick_weight());
      else
        put_op(CMD_REMOVE, find_node(1'b1), pick_weight());
    end

    // count is full: inserting linked nodes must hold it at the table size
    repeat (3) put_op(CMD_INSERT, int'($urandom_range(0, NODE_COUNT - 1)), pick_weight());

    // noise on a corrupted list; every node has been written by now
    repeat (20)
      put_op(1'($urandom_range(0, 1)), int'($urandom_range(0, NODE_COUNT - 1)),
             pick_weight());

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sorted_weight_list_engine_core.f
src/swle_pkg.sv
src/swle_ram.sv
src/swle_ctrl.sv
src/sorted_weight_list_engine_core.sv
tb/weight_list_checker.sv
tb/sorted_weight_list_engine_core_tb.sv
